// ===== rtl/core/upv_pkg.sv =====
package upv_pkg;

  // Width of the byte position counter and its saturation value
  localparam int unsigned POS_W = 9;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Segment length counter saturates at three
  localparam int unsigned SEG_W = 2;
  localparam logic [SEG_W-1:0] SEG_MAX = '1;

  // Scheme prefix register
  localparam int unsigned PREFIX_W = 56;
  localparam logic [PREFIX_W-1:0] PREFIX_RESET = 56'h6E616F733A2F2F;

  // Path punctuation
  localparam logic [7:0] CHAR_DASH       = 8'h2D;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_TILDE      = 8'h7E;
  localparam logic [7:0] CHAR_DOT        = 8'h2E;
  localparam logic [7:0] CHAR_SLASH      = 8'h2F;

  // Character classes of one byte
  typedef struct packed {
    logic is_slash;
    logic is_dot;
    logic path_ok;
  } char_class_t;

endpackage

// ===== rtl/core/upv_classify.sv =====
module upv_classify (
  input  logic [7:0]           char_byte,
  output upv_pkg::char_class_t cls
);

  logic is_lower;
  logic is_upper;
  logic is_digit;
  logic is_punct;

  // Sort the byte into letter, digit and allowed punctuation
  always_comb begin
    is_lower = (char_byte >= 8'h61) && (char_byte <= 8'h7A);
    is_upper = (char_byte >= 8'h41) && (char_byte <= 8'h5A);
    is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
    is_punct = (char_byte == upv_pkg::CHAR_DASH) ||
               (char_byte == upv_pkg::CHAR_UNDERSCORE) ||
               (char_byte == upv_pkg::CHAR_DOT) ||
               (char_byte == upv_pkg::CHAR_TILDE);
    cls.is_slash = (char_byte == upv_pkg::CHAR_SLASH);
    cls.is_dot   = (char_byte == upv_pkg::CHAR_DOT);
    cls.path_ok  = is_lower || is_upper || is_digit || is_punct;
  end

endmodule

// ===== rtl/core/upv_tracker.sv =====
module upv_tracker #(
  parameter int unsigned PREFIX_LEN = 7,
  parameter int unsigned MAX_LEN    = 255
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [7:0]                   char_byte,
  input  logic                         last,
  input  upv_pkg::char_class_t         cls,
  input  logic [upv_pkg::PREFIX_W-1:0] scheme_prefix,
  output logic                         verdict
);

  localparam logic [upv_pkg::POS_W-1:0] PrefixPos = upv_pkg::POS_W'(PREFIX_LEN);
  localparam logic [upv_pkg::POS_W-1:0] MaxPos    = upv_pkg::POS_W'(MAX_LEN);
  localparam logic [2:0]                PrefixTop = 3'(PREFIX_LEN - 1);

  logic [upv_pkg::POS_W-1:0] byte_position;
  logic                      reject_seen;
  logic                      segment_nonempty;
  logic                      segment_all_dots;
  logic [upv_pkg::SEG_W-1:0] segment_length;

  logic [upv_pkg::POS_W-1:0] byte_position_next;
  logic                      reject_seen_next;
  logic                      segment_nonempty_next;
  logic                      segment_all_dots_next;
  logic [upv_pkg::SEG_W-1:0] segment_length_next;

  logic [63:0] prefix_ext;
  logic [2:0]  prefix_idx;
  logic [7:0]  prefix_byte;
  logic        in_prefix;

  // Pick the expected prefix byte; an eighth byte reads as zero
  always_comb begin
    prefix_ext  = {8'h00, scheme_prefix};
    prefix_idx  = PrefixTop - byte_position[2:0];
    prefix_byte = prefix_ext[{prefix_idx, 3'b000} +: 8];
    in_prefix   = byte_position < PrefixPos;
  end

  // Per-byte rule update
  always_comb begin
    reject_seen_next      = reject_seen || (byte_position >= MaxPos);
    segment_nonempty_next = segment_nonempty;
    segment_all_dots_next = segment_all_dots;
    segment_length_next   = segment_length;

    priority if (in_prefix) begin
      if (char_byte != prefix_byte) reject_seen_next = 1'b1;
    end else if (cls.is_slash) begin
      if (!segment_nonempty || segment_all_dots) reject_seen_next = 1'b1;
      segment_nonempty_next = 1'b0;
      segment_all_dots_next = 1'b1;
      segment_length_next   = '0;
    end else if (!cls.path_ok) begin
      reject_seen_next = 1'b1;
    end else begin
      segment_nonempty_next = 1'b1;
      if (segment_length != upv_pkg::SEG_MAX) begin
        segment_length_next = segment_length + 1'b1;
      end
      if ((segment_length_next == upv_pkg::SEG_MAX) || !cls.is_dot) begin
        segment_all_dots_next = 1'b0;
      end
    end

    byte_position_next = (byte_position == upv_pkg::POS_MAX) ?
                         byte_position : byte_position + 1'b1;

    verdict = !reject_seen_next && !in_prefix &&
              segment_nonempty_next && !segment_all_dots_next;
  end

  // Advance the URI state; drop it after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      reject_seen      <= 1'b0;
      segment_nonempty <= 1'b0;
      segment_all_dots <= 1'b1;
      segment_length   <= '0;
    end else if (step) begin
      if (last) begin
        byte_position    <= '0;
        reject_seen      <= 1'b0;
        segment_nonempty <= 1'b0;
        segment_all_dots <= 1'b1;
        segment_length   <= '0;
      end else begin
        byte_position    <= byte_position_next;
        reject_seen      <= reject_seen_next;
        segment_nonempty <= segment_nonempty_next;
        segment_all_dots <= segment_all_dots_next;
        segment_length   <= segment_length_next;
      end
    end
  end

  // A segment has bytes exactly when its length count is nonzero
  a_seg_len_matches: assert property (@(posedge clk) disable iff (rst)
    (segment_length == '0) == !segment_nonempty)
    else $error("segment length and nonempty flag disagree");

  // The last byte leaves a fresh URI state behind
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && last |=> (byte_position == '0) && !reject_seen && segment_all_dots)
    else $error("URI state not cleared after last byte");

endmodule

// ===== rtl/core/uri_path_validator.sv =====
// Channel   Valid          Stall          Payload
// request   byte_valid     byte_stall     char_in, last_byte
// verdict   verdict_valid  verdict_stall  uri_valid
// prefix    prefix_we      (none)         prefix_wdata
//
// One byte per cycle while the input is not stalled. A byte waits in the input
// register, then the rule logic updates the URI state and, on a last byte, loads
// the verdict register once that register has room for it.
// Reset clears the pipeline and URI state and loads the default prefix.
// A held verdict blocks only a last byte in the input register, which then
// stalls the input; other bytes keep flowing.
module uri_path_validator #(
  parameter int unsigned PREFIX_LEN = 7,
  parameter int unsigned MAX_LEN    = 255
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         byte_valid,
  output logic                         byte_stall,
  input  logic [7:0]                   char_in,
  input  logic                         last_byte,
  output logic                         verdict_valid,
  input  logic                         verdict_stall,
  output logic                         uri_valid,
  input  logic                         prefix_we,
  input  logic [upv_pkg::PREFIX_W-1:0] prefix_wdata
);

  logic                         s1_valid;
  logic [7:0]                   s1_char;
  logic                         s1_last;
  logic [upv_pkg::PREFIX_W-1:0] prefix_reg;

  logic                 out_free;
  logic                 s1_advance;
  logic                 byte_take;
  logic                 verdict;
  upv_pkg::char_class_t cls;

  // Handshake: a last byte waits for room in the verdict register
  always_comb begin
    out_free   = !verdict_valid || !verdict_stall;
    s1_advance = s1_valid && (!s1_last || out_free);
    byte_stall = s1_valid && !s1_advance;
    byte_take  = byte_valid && !byte_stall;
  end

  // Hold the scheme prefix
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_reg <= upv_pkg::PREFIX_RESET;
    end else if (prefix_we) begin
      prefix_reg <= prefix_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      s1_char <= char_in;
      s1_last <= last_byte;
    end
  end

  upv_classify u_classify (
    .char_byte (s1_char),
    .cls       (cls)
  );

  upv_tracker #(
    .PREFIX_LEN (PREFIX_LEN),
    .MAX_LEN    (MAX_LEN)
  ) u_tracker (
    .clk           (clk),
    .rst           (rst),
    .step          (s1_advance),
    .char_byte     (s1_char),
    .last          (s1_last),
    .cls           (cls),
    .scheme_prefix (prefix_reg),
    .verdict       (verdict)
  );

  // Verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      verdict_valid <= 1'b1;
    end else if (out_free) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last) begin
      uri_valid <= verdict;
    end
  end

  // A verdict appears only after a last byte went through the rule logic
  a_verdict_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(verdict_valid) |-> $past(s1_valid && s1_last))
    else $error("verdict raised without a last byte");

  // Input stalls only behind a last byte that waits on a held verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> s1_valid && s1_last && verdict_valid && verdict_stall)
    else $error("input stalled without a pending verdict");

endmodule
